/* rtl/erp3_pkg.sv */
// ----------------------------------------------------------------------------
// erp3_pkg
// Shared types, constants and arithmetic helpers for the ZYX Euler rotation
// ----------------------------------------------------------------------------
package erp3_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;
    localparam int ANGLE_FRAC  = ANGLE_WIDTH - 3;
    localparam int QB          = 30;
    localparam int NSTEP       = 5;

    localparam logic signed [33:0] ONE_Q     = 34'sd1073741824;
    localparam logic signed [33:0] PI_Q      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd1686629713;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
        logic signed [ANGLE_WIDTH-1:0] angle_yaw;
        logic signed [ANGLE_WIDTH-1:0] angle_pitch;
        logic signed [ANGLE_WIDTH-1:0] angle_roll;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic signed [COORD_WIDTH-1:0] rotated_z;
        logic                          saturated;
    } t_out_beat;

    // per-angle reduction state: magnitude, sign and flip
    typedef struct packed {
        logic [31:0] m;
        logic        neg;
        logic        flip;
    } t_red;

    // floor quotient by a constant: shift out the power of two, then multiply
    // by the rounded-up reciprocal of the odd part, exact for any 32-bit n
    function automatic logic [31:0] rcp_div(input logic [31:0] n, input int pre,
                                            input logic [31:0] rcp, input int post);
        logic [63:0] p;
        p = 64'(n >> pre) * 64'(rcp);
        rcp_div = 32'(p >> post);
    endfunction

    // horner divisors for the sine: 110, 72, 42, 20, 6
    function automatic logic [31:0] sin_quot(input logic [31:0] n, input int i);
        unique case (i)
            0: sin_quot = rcp_div(n, 1, 32'd2498890064, 37);
            1: sin_quot = rcp_div(n, 3, 32'd3817748708, 35);
            2: sin_quot = rcp_div(n, 1, 32'd3272356036, 36);
            3: sin_quot = rcp_div(n, 2, 32'd3435973837, 34);
            default: sin_quot = rcp_div(n, 1, 32'd2863311531, 33);
        endcase
    endfunction

    // horner divisors for the cosine: 132, 90, 56, 30, 12
    function automatic logic [31:0] cos_quot(input logic [31:0] n, input int i);
        unique case (i)
            0: cos_quot = rcp_div(n, 2, 32'd4164816772, 37);
            1: cos_quot = rcp_div(n, 1, 32'd3054198967, 37);
            2: cos_quot = rcp_div(n, 3, 32'd2454267027, 34);
            3: cos_quot = rcp_div(n, 1, 32'd2290649225, 35);
            default: cos_quot = rcp_div(n, 2, 32'd2863311531, 33);
        endcase
    endfunction

    // unsigned q30 product, floor
    function automatic logic [31:0] umulq(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        umulq = 32'(p >> QB);
    endfunction

    // signed q30 product, round half up
    function automatic logic signed [33:0] smulq(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + (68'sd1 <<< (QB - 1));
        smulq = 34'(p >>> QB);
    endfunction

    function automatic logic signed [33:0] clamp_one(input logic signed [33:0] v);
        if (v > ONE_Q) clamp_one = ONE_Q;
        else if (v < -ONE_Q) clamp_one = -ONE_Q;
        else clamp_one = v;
    endfunction

endpackage

/* rtl/euler_rotate_point_3d_top.sv */
// ----------------------------------------------------------------------------
// euler_rotate_point_3d_top
// Rotates one 3D point per beat by R = Rz(yaw) * Ry(pitch) * Rx(roll)
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries the point and three angles, output
// channel o_valid/i_ready carries the rotated point and a clamp flag.
// The datapath is an 18-stage pipeline: angle reduction, x^2, five Horner
// steps each split into a multiply stage and a divide-by-constant stage,
// final sine/cosine, two matrix product levels, coordinate products, sum and
// saturation. Throughput is one beat per cycle; every stage advances
// together while the last stage is empty or being taken, so a stall
// from the receiver freezes the whole pipeline without losing or
// repeating beats. Synchronous active-low reset clears all valid bits;
// payload registers are not reset.
module euler_rotate_point_3d_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  erp3_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output erp3_pkg::t_out_beat o_data
);
    import erp3_pkg::*;

    localparam int NS = 18;
    localparam int HS = 2 * NSTEP; // horner stages

    logic          adv;
    logic [NS-1:0] r_vld;

    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];

    // valid shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // coordinates ride along until the coordinate products
    logic signed [COORD_WIDTH-1:0] r_cx [16];
    logic signed [COORD_WIDTH-1:0] r_cy [16];
    logic signed [COORD_WIDTH-1:0] r_cz [16];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0] <= i_data.coord_x;
            r_cy[0] <= i_data.coord_y;
            r_cz[0] <= i_data.coord_z;
            for (int k = 1; k < 16; k++) begin
                r_cx[k] <= r_cx[k-1];
                r_cy[k] <= r_cy[k-1];
                r_cz[k] <= r_cz[k-1];
            end
        end
    end

    // stage 0: range reduction into magnitude below pi/2
    t_red n_red [3];
    t_red r_red [3];
    always_comb begin
        logic signed [33:0] a;
        logic [ANGLE_WIDTH-1:0] ang [3];
        ang[0] = i_data.angle_yaw;
        ang[1] = i_data.angle_pitch;
        ang[2] = i_data.angle_roll;
        for (int j = 0; j < 3; j++) begin
            a = 34'(signed'(ang[j])) <<< (QB - ANGLE_FRAC);
            n_red[j].flip = 1'b0;
            if (a > HALF_PI_Q) begin
                a = a - PI_Q;
                n_red[j].flip = 1'b1;
            end else if (a < -HALF_PI_Q) begin
                a = a + PI_Q;
                n_red[j].flip = 1'b1;
            end
            n_red[j].neg = a[33];
            n_red[j].m   = a[33] ? 32'(-a) : 32'(a);
        end
    end

    // reduction state carried through all sine/cosine stages
    t_red r_rp [3][HS+2];
    logic [31:0] r_x2 [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_red[j]   <= n_red[j];
                r_rp[j][0] <= r_red[j];
                r_x2[j]    <= umulq(r_red[j].m, r_red[j].m);
                for (int k = 1; k < HS + 2; k++) r_rp[j][k] <= r_rp[j][k-1];
            end
        end
    end

    // horner pipeline: even stages multiply, odd stages divide and subtract
    logic [31:0] r_x2p [3][HS];
    logic [31:0] r_qs  [3][HS];
    logic [31:0] r_qc  [3][HS];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_x2p[j][0] <= r_x2[j];
                r_qs[j][0]  <= umulq(r_x2[j], 32'(ONE_Q));
                r_qc[j][0]  <= umulq(r_x2[j], 32'(ONE_Q));
                for (int k = 1; k < HS; k++) begin
                    r_x2p[j][k] <= r_x2p[j][k-1];
                    if (k % 2 == 0) begin
                        r_qs[j][k] <= umulq(r_x2p[j][k-1], r_qs[j][k-1]);
                        r_qc[j][k] <= umulq(r_x2p[j][k-1], r_qc[j][k-1]);
                    end else begin
                        r_qs[j][k] <= 32'(ONE_Q) - sin_quot(r_qs[j][k-1], k / 2);
                        r_qc[j][k] <= 32'(ONE_Q) - cos_quot(r_qc[j][k-1], k / 2);
                    end
                end
            end
        end
    end

    // final sine/cosine, two stages
    logic [31:0]        r_sm [3];
    logic [31:0]        r_cm [3];
    logic signed [33:0] r_s  [3];
    logic signed [33:0] r_c  [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_sm[j] <= umulq(r_rp[j][HS].m, r_qs[j][HS-1]);
                r_cm[j] <= umulq(r_x2p[j][HS-1], r_qc[j][HS-1]);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        logic signed [33:0] sv, cv;
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                sv = clamp_one(34'(r_sm[j]));
                if (r_rp[j][HS+1].neg) sv = -sv;
                cv = clamp_one(ONE_Q - 34'(r_cm[j] >> 1));
                if (r_rp[j][HS+1].flip) begin
                    sv = -sv;
                    cv = -cv;
                end
                r_s[j] <= sv;
                r_c[j] <= cv;
            end
        end
    end

    // matrix level one: pairwise products
    logic signed [33:0] r_cacb, r_sacb, r_casb, r_sasb, r_sacg, r_sasg;
    logic signed [33:0] r_cacg, r_casg, r_cbsg, r_cbcg, r_sb1, r_sg1, r_cg1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cacb <= smulq(r_c[0], r_c[1]);
            r_sacb <= smulq(r_s[0], r_c[1]);
            r_casb <= smulq(r_c[0], r_s[1]);
            r_sasb <= smulq(r_s[0], r_s[1]);
            r_sacg <= smulq(r_s[0], r_c[2]);
            r_sasg <= smulq(r_s[0], r_s[2]);
            r_cacg <= smulq(r_c[0], r_c[2]);
            r_casg <= smulq(r_c[0], r_s[2]);
            r_cbsg <= smulq(r_c[1], r_s[2]);
            r_cbcg <= smulq(r_c[1], r_c[2]);
            r_sb1  <= r_s[1];
            r_sg1  <= r_s[2];
            r_cg1  <= r_c[2];
        end
    end

    // matrix level two: full entries
    logic signed [33:0] r_e [9];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e[0] <= r_cacb;
            r_e[1] <= smulq(r_casb, r_sg1) - r_sacg;
            r_e[2] <= smulq(r_casb, r_cg1) + r_sasg;
            r_e[3] <= r_sacb;
            r_e[4] <= smulq(r_sasb, r_sg1) + r_cacg;
            r_e[5] <= smulq(r_sasb, r_cg1) - r_casg;
            r_e[6] <= -r_sb1;
            r_e[7] <= r_cbsg;
            r_e[8] <= r_cbcg;
        end
    end

    // coordinate products
    logic signed [33:0] r_t [9];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_t[3*r]   <= smulq(r_e[3*r],   34'(r_cx[15]));
                r_t[3*r+1] <= smulq(r_e[3*r+1], 34'(r_cy[15]));
                r_t[3*r+2] <= smulq(r_e[3*r+2], 34'(r_cz[15]));
            end
        end
    end

    // row sums and saturation
    t_out_beat r_out;
    always_ff @(posedge i_clk) begin
        logic signed [35:0] v;
        logic signed [COORD_WIDTH-1:0] res [3];
        logic sat;
        if (adv) begin
            sat = 1'b0;
            for (int r = 0; r < 3; r++) begin
                v = 36'(r_t[3*r]) + 36'(r_t[3*r+1]) + 36'(r_t[3*r+2]);
                if (v > 36'((64'sd1 <<< (COORD_WIDTH - 1)) - 1)) begin
                    res[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
                    sat = 1'b1;
                end else if (v < -36'(64'sd1 <<< (COORD_WIDTH - 1))) begin
                    res[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
                    sat = 1'b1;
                end else begin
                    res[r] = v[COORD_WIDTH-1:0];
                end
            end
            r_out.rotated_x <= res[0];
            r_out.rotated_y <= res[1];
            r_out.rotated_z <= res[2];
            r_out.saturated <= sat;
        end
    end

    assign o_data = r_out;

endmodule

/* rtl/erp3_checker.sv */
// ----------------------------------------------------------------------------
// erp3_checker
// Port-level checks on the rotation pipeline
// ----------------------------------------------------------------------------
module erp3_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input erp3_pkg::t_out_beat o_data
);
    import erp3_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // input side is open whenever output is empty
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

    // clamp flag implies an extreme component
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.saturated |->
            (o_data.rotated_x[COORD_WIDTH-2:0] == '1 && !o_data.rotated_x[COORD_WIDTH-1])
         || (o_data.rotated_x[COORD_WIDTH-2:0] == '0 &&  o_data.rotated_x[COORD_WIDTH-1])
         || (o_data.rotated_y[COORD_WIDTH-2:0] == '1 && !o_data.rotated_y[COORD_WIDTH-1])
         || (o_data.rotated_y[COORD_WIDTH-2:0] == '0 &&  o_data.rotated_y[COORD_WIDTH-1])
         || (o_data.rotated_z[COORD_WIDTH-2:0] == '1 && !o_data.rotated_z[COORD_WIDTH-1])
         || (o_data.rotated_z[COORD_WIDTH-2:0] == '0 &&  o_data.rotated_z[COORD_WIDTH-1]))
        else $error("clamp flag without clamped component");

endmodule

bind euler_rotate_point_3d_top erp3_checker u_erp3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
